// ===== sv/abr_pkg.sv =====
// Shared types and codes for the allocation bounds registry.
package abr_pkg;

    localparam int ADDR_W   = 48;
    localparam int SIZE_W   = 32;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int LIVE_W   = 7;

    localparam logic [OP_W-1:0] OP_REGISTER   = 2'd0;
    localparam logic [OP_W-1:0] OP_UNREGISTER = 2'd1;
    localparam logic [OP_W-1:0] OP_CHECK      = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [ADDR_W-1:0] address;
        logic [SIZE_W-1:0] length;
    } t_in;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                matched;
        logic [LIVE_W-1:0]   live_entries;
    } t_out;

    // Controller to datapath commands.
    typedef struct packed {
        logic                load;
        logic                idx_inc;
        logic                rd_last;
        logic                wr_new;
        logic                wr_move;
        logic                res_set;
        logic [STATUS_W-1:0] res_status;
        logic                res_matched;
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            empty;
        logic            hit_base;
        logic            hit_own;
        logic            idx_last;
    } t_sts;

endpackage

// ===== sv/abr_dpath.sv =====
// Datapath: entry memory, live count, scan index, compare logic and result register.
module abr_dpath #(
    parameter int ENTRIES = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  abr_pkg::t_in  i_item,
    input  abr_pkg::t_cmd i_cmd,
    output abr_pkg::t_sts o_sts,
    output abr_pkg::t_out o_result
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    logic [abr_pkg::ADDR_W-1:0] mem_base [ENTRIES];
    logic [abr_pkg::SIZE_W-1:0] mem_size [ENTRIES];

    logic [abr_pkg::OP_W-1:0]     r_op;
    logic [abr_pkg::ADDR_W-1:0]   r_addr;
    logic [abr_pkg::SIZE_W-1:0]   r_len;
    logic [IDX_W-1:0]             r_idx;
    logic [CNT_W-1:0]             r_count;
    logic [abr_pkg::ADDR_W-1:0]   r_rd_base;
    logic [abr_pkg::SIZE_W-1:0]   r_rd_size;
    logic [abr_pkg::STATUS_W-1:0] r_status;
    logic                         r_matched;

    logic [IDX_W-1:0]                   last_idx;
    logic [IDX_W-1:0]                   rd_addr;
    logic [abr_pkg::ADDR_W-1:0]         diff;
    logic [CNT_W+abr_pkg::LIVE_W-1:0]   live_ext;

    assign last_idx = IDX_W'(r_count - CNT_W'(1));
    assign rd_addr  = i_cmd.rd_last ? last_idx : r_idx;
    assign diff     = r_addr - r_rd_base;
    assign live_ext = {{abr_pkg::LIVE_W{1'b0}}, r_count};

    // Latch the command beat, step the scan index and set the result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_item.operation;
            r_addr <= i_item.address;
            r_len  <= i_item.length;
        end
        if (i_cmd.load) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + IDX_W'(1);
        end
        if (i_cmd.res_set) begin
            r_status  <= i_cmd.res_status;
            r_matched <= i_cmd.res_matched;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.wr_new) begin
            r_count <= r_count + CNT_W'(1);
        end else if (i_cmd.wr_move) begin
            r_count <= r_count - CNT_W'(1);
        end
    end

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_new) begin
            mem_base[r_count[IDX_W-1:0]] <= r_addr;
            mem_size[r_count[IDX_W-1:0]] <= r_len;
        end else if (i_cmd.wr_move) begin
            mem_base[r_idx] <= r_rd_base;
            mem_size[r_idx] <= r_rd_size;
        end
        r_rd_base <= mem_base[rd_addr];
        r_rd_size <= mem_size[rd_addr];
    end

    always_comb begin
        o_sts.op       = r_op;
        o_sts.full     = (r_count == CNT_W'(ENTRIES));
        o_sts.empty    = (r_count == '0);
        o_sts.hit_base = (r_rd_base == r_addr);
        o_sts.hit_own  = (r_addr >= r_rd_base) &&
                         (diff < abr_pkg::ADDR_W'(r_rd_size));
        o_sts.idx_last = (r_idx == last_idx);
    end

    always_comb begin
        o_result.status       = r_status;
        o_result.matched      = r_matched;
        o_result.live_entries = live_ext[abr_pkg::LIVE_W-1:0];
    end

endmodule

// ===== sv/abr_ctrl.sv =====
// Controller: sequences register, unregister and check over the entry memory.
module abr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  abr_pkg::t_sts i_sts,
    output abr_pkg::t_cmd o_cmd,
    output logic          o_busy,
    output logic          o_done
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_RD,
        S_CMP,
        S_FETCH,
        S_MOVE,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;
    logic   r_done;

    assign o_busy = r_busy;
    assign o_done = r_done;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                o_cmd.res_set    = 1'b1;
                o_cmd.res_status = abr_pkg::ST_OK;
                n_state          = S_DONE;
                priority if (i_sts.op == abr_pkg::OP_REGISTER) begin
                    if (i_sts.full) begin
                        o_cmd.res_status = abr_pkg::ST_FULL;
                    end else begin
                        o_cmd.wr_new = 1'b1;
                    end
                end else if (i_sts.op == abr_pkg::OP_UNREGISTER ||
                             i_sts.op == abr_pkg::OP_CHECK) begin
                    if (i_sts.empty) begin
                        if (i_sts.op == abr_pkg::OP_CHECK) begin
                            o_cmd.res_status = abr_pkg::ST_MISS;
                        end
                    end else begin
                        o_cmd.res_set = 1'b0;
                        n_state       = S_RD;
                    end
                end else begin
                    // unused code: report ok and leave the table alone
                    o_cmd.res_status = abr_pkg::ST_OK;
                end
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                priority if (i_sts.op == abr_pkg::OP_UNREGISTER && i_sts.hit_base) begin
                    n_state = S_FETCH;
                end else if (i_sts.op == abr_pkg::OP_CHECK && i_sts.hit_own) begin
                    o_cmd.res_set     = 1'b1;
                    o_cmd.res_status  = abr_pkg::ST_OK;
                    o_cmd.res_matched = 1'b1;
                    n_state           = S_DONE;
                end else if (i_sts.idx_last) begin
                    o_cmd.res_set    = 1'b1;
                    o_cmd.res_status = (i_sts.op == abr_pkg::OP_CHECK) ?
                                       abr_pkg::ST_MISS : abr_pkg::ST_OK;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_RD;
                end
            end
            S_FETCH: begin
                o_cmd.rd_last = 1'b1;
                n_state       = S_MOVE;
            end
            S_MOVE: begin
                o_cmd.wr_move     = 1'b1;
                o_cmd.res_set     = 1'b1;
                o_cmd.res_status  = abr_pkg::ST_OK;
                o_cmd.res_matched = 1'b1;
                n_state           = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
            r_done  <= (n_state == S_DONE);
        end
    end

endmodule

// ===== sv/allocation_bounds_registry.sv =====
// Register and unused codes go from dispatch straight to the result beat once start is taken.
// Check and unregister walk the table through one memory read port, with a read
// and a compare state per entry examined; an unregister hit adds a fetch and a
// move state to move the last entry. Throughput: one operation at a time; busy
// stays high through the result beat, so the next beat is taken in the cycle after it.
// Reset (synchronous, active low) empties the table and returns to idle; no clear pass.
module allocation_bounds_registry #(
    parameter int ENTRIES = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  abr_pkg::t_in  i_item,
    output logic          busy,
    output logic          o_done,
    output abr_pkg::t_out o_result
);

    // The result beat is shown on o_done for one cycle and cannot be held off.

    // Command and status groups between the controller and the datapath.
    abr_pkg::t_cmd cmd;
    abr_pkg::t_sts sts;

    // Controller: accepts a beat when start is high and busy is low, then
    // steps through dispatch, scan, move and result states.
    abr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    // Datapath: holds the base and size memories, the live count, and the
    // registered result; the result is stable while o_done is high.
    abr_dpath #(
        .ENTRIES (ENTRIES)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_result (o_result)
    );

endmodule
